[hw/rtl/best_fit_heap_allocator_assert.svh]
// Assertion macros used by the checker of the heap allocator.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Clocked check that is ignored while reset is asserted.
`define BFHA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("heap allocator check failed");

// Clocked check that also holds during reset.
`define BFHA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("heap allocator check failed");

`endif

[hw/rtl/bfha_pkg.sv]
// Shared types and constants of the best-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps

package bfha_pkg;

    localparam int unsigned DEF_HEAP_WORDS  = 65536;
    localparam int unsigned HDR_WORDS       = 2;
    localparam int unsigned SPLIT_MIN_WORDS = 4;
    localparam logic [16:0] LIMIT_RESET     = 17'd65536;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_USED = 2'd1,
        TAG_FREE = 2'd2
    } t_tag;

    typedef struct packed {
        logic clr;
        logic load;
        logic decode;
        logic walk_rd;
        logic walk_ev;
        logic alloc_fin;
        logic loc_ev;
        logic rel_chk;
        logic merge_rd;
        logic merge_ev;
        logic merge_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic bytes_zero;
        logic loc_ok;
        logic walk_more;
        logic walk_stop;
        logic found;
        logic split;
        logic tag_used;
        logic top_rel;
        logic merge_more;
        logic merge_go;
    } t_sts;

endpackage

[hw/rtl/bfha_ctrl.sv]
// Sequencer of the heap allocator: walks allocate, release and query items.
// Depends on bfha_pkg; drives bfha_dp through command and status structs.
`timescale 1ns / 1ps

module bfha_ctrl
    import bfha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_done
);

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_DECODE    = 13'b0000000000100,
        S_WALK_RD   = 13'b0000000001000,
        S_WALK_EV   = 13'b0000000010000,
        S_ALLOC_FIN = 13'b0000000100000,
        S_LOC_RD    = 13'b0000001000000,
        S_LOC_EV    = 13'b0000010000000,
        S_REL_CHK   = 13'b0000100000000,
        S_MERGE_RD  = 13'b0001000000000,
        S_MERGE_EV  = 13'b0010000000000,
        S_MERGE_WR  = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_sts.op)
                    OP_ALLOC: n_state = i_sts.bytes_zero ? S_DONE : S_WALK_RD;
                    OP_FREE:  n_state = i_sts.loc_ok ? S_LOC_RD : S_DONE;
                    OP_QUERY: n_state = i_sts.loc_ok ? S_LOC_RD : S_DONE;
                    OP_NONE:  n_state = S_DONE;
                endcase
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = i_sts.walk_more ? S_WALK_EV : S_ALLOC_FIN;
            end
            S_WALK_EV: begin
                o_cmd.walk_ev = 1'b1;
                n_state = i_sts.walk_stop ? S_ALLOC_FIN : S_WALK_RD;
            end
            S_ALLOC_FIN: begin
                o_cmd.alloc_fin = 1'b1;
                // A split-off remainder is released like any other block.
                n_state = (i_sts.found && i_sts.split) ? S_REL_CHK : S_DONE;
            end
            S_LOC_RD: begin
                n_state = S_LOC_EV;
            end
            S_LOC_EV: begin
                o_cmd.loc_ev = 1'b1;
                n_state = (i_sts.tag_used && i_sts.op == OP_FREE) ? S_REL_CHK : S_DONE;
            end
            S_REL_CHK: begin
                o_cmd.rel_chk = 1'b1;
                n_state = i_sts.top_rel ? S_DONE : S_MERGE_RD;
            end
            S_MERGE_RD: begin
                o_cmd.merge_rd = 1'b1;
                n_state = i_sts.merge_more ? S_MERGE_EV : S_MERGE_WR;
            end
            S_MERGE_EV: begin
                o_cmd.merge_ev = 1'b1;
                n_state = i_sts.merge_go ? S_MERGE_RD : S_MERGE_WR;
            end
            S_MERGE_WR: begin
                o_cmd.merge_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

[hw/rtl/bfha_dp.sv]
// Datapath of the heap allocator: header memory, walk and merge registers, result.
// Depends on bfha_pkg; sequenced by bfha_ctrl.
`timescale 1ns / 1ps

module bfha_dp
    import bfha_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = DEF_HEAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_base,
    input  logic [16:0] i_limit,
    input  logic [1:0]  i_opcode,
    input  logic [18:0] i_request_bytes,
    input  logic [31:0] i_block_address,
    output logic        o_success,
    output logic [31:0] o_payload_address,
    output logic [17:0] o_payload_bytes
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = AW + 1;
    localparam int CW = ((SW > 18) ? SW : 18) + 1;
    localparam int HW = SW + 2;

    logic [HW-1:0] mem [HEAP_WORDS];
    logic [HW-1:0] r_rdata;
    logic [AW-1:0] ra, wa;
    logic [HW-1:0] wd;
    logic          we;

    logic [AW-1:0] r_clr;
    logic [SW-1:0] r_top;
    t_op           r_op;
    logic          r_bzero;
    logic [31:0]   r_hdr;
    logic [CW-1:0] r_need, r_cur, r_left, r_bsz, r_sz, r_acc, r_next;
    logic [AW-1:0] r_best, r_w;
    logic          r_found;
    logic          r_ok;
    logic [31:0]   r_paddr;
    logic [17:0]   r_pbytes;

    logic [1:0]    rd_tag;
    logic [CW-1:0] rd_sz, top_c, eff, diff, pa_word, nw_sum;
    logic [32:0]   off;
    logic          better, split, fits;
    logic [31:0]   paddr;
    logic [CW+1:0] qbytes;

    assign rd_tag  = r_rdata[HW-1:SW];
    assign rd_sz   = CW'(r_rdata[SW-1:0]);
    assign top_c   = CW'(r_top);
    assign eff     = (CW'(i_limit) < CW'(HEAP_WORDS)) ? CW'(i_limit) : CW'(HEAP_WORDS);
    assign off     = {1'b0, r_hdr} - {1'b0, i_base};
    assign diff    = rd_sz - r_need;
    assign better  = (rd_tag == TAG_FREE) && (rd_sz >= r_need) && (!r_found || r_left > diff);
    assign split   = r_left > CW'(SPLIT_MIN_WORDS);
    assign fits    = (top_c + r_need) <= eff;
    assign pa_word = r_found ? CW'(r_best) : top_c;
    assign paddr   = i_base + 32'({pa_word + CW'(HDR_WORDS), 2'b00});
    assign nw_sum  = CW'(r_best) + r_need;
    assign qbytes  = {rd_sz, 2'b00} - (CW+2)'(8);

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr == AW'(HEAP_WORDS - 1));
        o_sts.op         = r_op;
        o_sts.bytes_zero = r_bzero;
        // The header address lies at or above the base, word aligned, below the top.
        o_sts.loc_ok     = !off[32] && (off[1:0] == 2'b00) &&
                           ({2'b00, off[31:2]} < 32'(r_top));
        o_sts.walk_more  = r_cur < top_c;
        o_sts.walk_stop  = (better && rd_sz == r_need) || (rd_sz == '0);
        o_sts.found      = r_found;
        o_sts.split      = split;
        o_sts.tag_used   = (rd_tag == TAG_USED);
        o_sts.top_rel    = (r_next == top_c) && (r_sz <= top_c);
        o_sts.merge_more = r_next < top_c;
        o_sts.merge_go   = (rd_tag == TAG_FREE) && (rd_sz != '0);
    end

    always_comb begin
        ra = r_w;
        if (i_cmd.walk_rd) begin
            ra = r_cur[AW-1:0];
        end else if (i_cmd.merge_rd) begin
            ra = r_next[AW-1:0];
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_w;
        wd = '0;
        if (i_cmd.clr) begin
            we = 1'b1;
            wa = r_clr;
        end else if (i_cmd.alloc_fin) begin
            if (r_found) begin
                we = 1'b1;
                wa = r_best;
                wd = {TAG_USED, SW'(split ? r_need : r_bsz)};
            end else if (fits) begin
                we = 1'b1;
                wa = r_top[AW-1:0];
                wd = {TAG_USED, SW'(r_need)};
            end
        end else if (i_cmd.rel_chk) begin
            if (o_sts.top_rel) begin
                we = 1'b1;
                wd = {TAG_FREE, SW'(r_sz)};
            end
        end else if (i_cmd.merge_wr) begin
            we = 1'b1;
            wd = {TAG_FREE, SW'(r_acc)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_top <= '0;
            r_op  <= OP_NONE;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.load) r_op <= t_op'(i_opcode);
            if (i_cmd.alloc_fin && !r_found && fits) r_top <= r_top + SW'(r_need);
            if (i_cmd.rel_chk && o_sts.top_rel) r_top <= r_top - SW'(r_sz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bzero  <= (i_request_bytes == '0);
            r_need   <= CW'((20'(i_request_bytes) + 20'd3) >> 2) + CW'(HDR_WORDS);
            r_hdr    <= i_block_address - 32'd8;
            r_cur    <= '0;
            r_found  <= 1'b0;
            r_ok     <= 1'b0;
            r_paddr  <= '0;
            r_pbytes <= '0;
        end
        if (i_cmd.decode) r_w <= off[2 +: AW];
        if (i_cmd.walk_ev) begin
            if (better) begin
                r_found <= 1'b1;
                r_left  <= diff;
                r_best  <= r_cur[AW-1:0];
                r_bsz   <= rd_sz;
            end
            r_cur <= r_cur + rd_sz;
        end
        if (i_cmd.alloc_fin) begin
            if (r_found || fits) begin
                r_ok    <= 1'b1;
                r_paddr <= paddr;
            end
            // The remainder is released right away like a used block.
            if (r_found && split) begin
                r_w    <= nw_sum[AW-1:0];
                r_sz   <= r_left;
                r_acc  <= r_left;
                r_next <= CW'(r_best) + r_bsz;
            end
        end
        if (i_cmd.loc_ev && rd_tag == TAG_USED) begin
            if (r_op == OP_QUERY) begin
                r_ok     <= 1'b1;
                r_pbytes <= qbytes[17:0];
            end
            r_sz   <= rd_sz;
            r_acc  <= rd_sz;
            r_next <= CW'(r_w) + rd_sz;
        end
        if (i_cmd.merge_ev && o_sts.merge_go) begin
            r_acc  <= r_acc + rd_sz;
            r_next <= r_next + rd_sz;
        end
    end

    assign o_success         = r_ok;
    assign o_payload_address = r_paddr;
    assign o_payload_bytes   = r_pbytes;

endmodule

[hw/rtl/best_fit_heap_allocator.sv]
// Top level of the best-fit heap allocator: configuration registers and wiring.
// Depends on bfha_pkg, bfha_ctrl and bfha_dp.
//
//   Channel   Handshake                          Fields
//   command   start high while busy low          i_opcode, i_request_bytes, i_block_address
//   result    o_done, one cycle, no stall        o_success, o_payload_address, o_payload_bytes
//   config    psel & penable & pwrite & pready   paddr, pwdata, prdata
//
// After reset the header memory is cleared one word a cycle with busy high. An allocate walks
// the headers for the best free fit, stopping early on an exact fit, then tags the found block,
// or a new one at the top, used; a split releases the remainder like any other block. Release
// of the top block lowers the top, else the free blocks that follow are merged until a used or
// empty header or the top. A query reads the header; a zero-byte or unused item, a failed range
// check or an untagged header ends the item with o_success low. The single header read port sets
// the pace of these steps, and start is taken again in the idle cycle after o_done; the receiver never stalls.
`timescale 1ns / 1ps

module best_fit_heap_allocator
    import bfha_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = DEF_HEAP_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [18:0] i_request_bytes,
    input  logic [31:0] i_block_address,
    output logic        o_done,
    output logic        o_success,
    output logic [31:0] o_payload_address,
    output logic [17:0] o_payload_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_base;
    logic [16:0] r_limit;
    logic        wr;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= LIMIT_RESET;
        end else if (wr) begin
            if (paddr[2] == REG_BASE) begin
                r_base <= {pwdata[31:2], 2'b00};
            end else begin
                r_limit <= pwdata[16:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_LIMIT) ? {15'd0, r_limit} : r_base;

    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    bfha_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_base            (r_base),
        .i_limit           (r_limit),
        .i_opcode          (i_opcode),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .o_success         (o_success),
        .o_payload_address (o_payload_address),
        .o_payload_bytes   (o_payload_bytes)
    );

endmodule

[hw/rtl/bfha_checker.sv]
// Port-level checks of the heap allocator, bound to the top level.
// Depends on best_fit_heap_allocator_assert.svh.
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_assert.svh"

module bfha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_success,
    input logic [31:0] o_payload_address,
    input logic [17:0] o_payload_bytes
);

    // An accepted item keeps the block busy until its result is shown.
    `BFHA_ASSERT(a_accept_busy, (start && !busy) |=> busy)
    // A result only appears while an item is in progress.
    `BFHA_ASSERT(a_done_busy, o_done |-> busy)
    // Exactly one result per item, so strobes never come back to back.
    `BFHA_ASSERT(a_done_single, o_done |=> !o_done)
    // A failed or release result carries all-zero fields.
    `BFHA_ASSERT_ALWAYS(a_fail_zero,
        (i_rst_n && o_done && !o_success) |-> (o_payload_address == 32'd0 &&
        o_payload_bytes == 18'd0))

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_success         (o_success),
    .o_payload_address (o_payload_address),
    .o_payload_bytes   (o_payload_bytes)
);
